// ===== hw/rtl/fvm_pkg.sv =====
// ----------------------------------------------------------------------------
// fvm_pkg: shared types and constants for the face normal/distance block
// Holds the sequencer states, the iterative unit modes and the saturation
// helpers used by the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fvm_pkg;

    localparam int COORD_W   = 32;
    localparam int VOL_W     = 32;
    localparam int CODE_W    = 6;
    localparam int IDX_W     = 20;
    localparam int NORM_W    = 16;
    localparam int DIST_W    = 32;
    localparam int WGT_W     = 48;
    localparam int NORM_FRAC = 14;
    localparam int FRAC_BITS = 16;

    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 152;

    // pre-shift of the weight dividend so the scale exponent is never negative
    localparam int WDIV_PRE = 16;

    localparam logic [2:0] SLOT_CELL = 3'd3;
    localparam logic [2:0] SLOT_NBR  = 3'd4;

    localparam logic [CODE_W-1:0] CODE_INTERIOR = 6'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_CROSS,
        ST_CHECK,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_NDIV,
        ST_DOT_T,
        ST_FLIP,
        ST_DOT_G,
        ST_VOL,
        ST_WDIV,
        ST_DONE
    } st_t;

    typedef enum logic [1:0] {
        IU_SQRT,
        IU_NDIV,
        IU_WDIV
    } iu_mode_t;

    typedef struct packed {
        logic     start;
        iu_mode_t mode;
    } iu_ctrl_t;

    function automatic logic is_wall(input logic [CODE_W-1:0] code);
        return (code inside {6'd3, 6'd4, 6'd5, 6'd7, 6'd9, 6'd10, 6'd36});
    endfunction

    // clamp an edge component to +-(2^31-1)
    function automatic logic signed [31:0] sat31(input logic signed [32:0] v);
        logic signed [32:0] lim;
        lim = 33'sh0_7FFF_FFFF;
        if (v > lim) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -lim) begin
            return -32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        if (v > 53'sh0_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -53'sh0_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fvm_mul.sv =====
// ----------------------------------------------------------------------------
// fvm_mul: shared signed multiplier
// One 33x33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module fvm_mul (
    input  wire logic               aclk,
    input  wire logic signed [32:0] op_a,
    input  wire logic signed [32:0] op_b,
    output logic signed [65:0]      prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fvm_iter_unit.sv =====
// ----------------------------------------------------------------------------
// fvm_iter_unit: shared iterative square root / divider
// One compare-and-subtract per cycle. Square root takes 32 steps, the normal
// division 15 steps and the weight division 96 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fvm_iter_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fvm_pkg::iu_ctrl_t ctrl,
    input  wire logic [95:0]      src_in,
    input  wire logic [65:0]      rem_in,
    input  wire logic [63:0]      dsr_in,
    output logic [65:0]           quo,
    output logic                  sticky,
    output logic                  done
);
    import fvm_pkg::*;

    iu_mode_t    mode_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  step_reg;
    logic [6:0]  last_step;
    logic [95:0] src_reg;
    logic [65:0] rem_reg;
    logic [63:0] dsr_reg;
    logic [65:0] quo_reg;
    logic        sticky_reg;

    logic [65:0] cand;
    logic [65:0] trial;
    logic [66:0] diff;
    logic        ge;
    logic [65:0] rem_next;
    logic [95:0] src_next;

    always_comb begin
        cand     = rem_reg;
        trial    = {2'b00, dsr_reg};
        src_next = src_reg;
        case (mode_reg)
            IU_SQRT: begin
                cand     = {rem_reg[63:0], src_reg[95:94]};
                trial    = {quo_reg[63:0], 2'b01};
                src_next = {src_reg[93:0], 2'b00};
                last_step = 7'd31;
            end
            IU_NDIV: begin
                last_step = 7'd14;
            end
            IU_WDIV: begin
                cand     = {rem_reg[64:0], src_reg[95]};
                src_next = {src_reg[94:0], 1'b0};
                last_step = 7'd95;
            end
            default: begin
                last_step = 7'd0;
            end
        endcase
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[66];
        if (mode_reg == IU_NDIV) begin
            rem_next = ge ? {diff[64:0], 1'b0} : {cand[64:0], 1'b0};
        end else begin
            rem_next = ge ? diff[65:0] : cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            mode_reg <= IU_SQRT;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                mode_reg <= ctrl.mode;
            end else if (busy_reg) begin
                step_reg <= step_reg + 7'd1;
                if (step_reg == last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            src_reg    <= src_in;
            rem_reg    <= rem_in;
            dsr_reg    <= dsr_in;
            quo_reg    <= '0;
            sticky_reg <= 1'b0;
        end else if (busy_reg) begin
            src_reg    <= src_next;
            rem_reg    <= rem_next;
            quo_reg    <= {quo_reg[64:0], ge};
            sticky_reg <= sticky_reg | quo_reg[65];
        end
    end

    assign quo    = quo_reg;
    assign sticky = sticky_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fvm_face_normal_distance.sv =====
// ----------------------------------------------------------------------------
// fvm_face_normal_distance: triangular face normal, distance and weight
// Loads three face nodes and two cell centres, then computes the unit face
// normal, the boundary-dependent normal distance and the gradient weight.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  s_      | in  | coords, volume, boundary code, neighbor | point slot
//  m_      | out | normal, distance, weight, neighbor      | degenerate
//
//  Beats on slots 0..3 only load registers. A slot 4 beat keeps s_tready
//  low for the whole computation, whose length is set mostly by the shared
//  square root / divider unit (32 + 3x15 + 96 steps) and the normalizing
//  shift loop; a degenerate face skips both. The shared multiplier issues
//  one product a cycle. s_tready is low while a face is computed and while
//  its result waits for the output register. Reset is synchronous, active
//  low.
// ----------------------------------------------------------------------------
`default_nettype none

module fvm_face_normal_distance (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // coord_x, coord_y, coord_z, cell_volume, boundary_code, neighbor_index
    input  wire logic [fvm_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  wire logic [2:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // normal_x, normal_y, normal_z, distance, weight_gradient, neighbor_out
    output logic [fvm_pkg::M_DATA_W-1:0]       m_tdata,
    // degenerate
    output logic [0:0]                         m_tuser
);
    import fvm_pkg::*;

    st_t state_reg, state_next;

    logic signed [31:0] node_reg [0:8];
    logic signed [31:0] cen_reg  [0:2];
    logic signed [31:0] pn_reg   [0:2];
    logic [31:0]        vi_reg, vj_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [IDX_W-1:0]   nbr_reg;

    logic signed [31:0] a_reg [0:2];
    logic signed [31:0] b_reg [0:2];
    logic signed [63:0] c_reg [0:2];
    logic [63:0]        u_reg [0:2];
    logic signed [6:0]  s_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        m_reg;
    logic signed [15:0] nrm_reg [0:2];
    logic signed [51:0] t_reg, g_reg;
    logic [63:0]        p_reg;
    logic [WGT_W-1:0]   wgt_reg;
    logic               deg_reg;
    logic [2:0]         cnt_reg;
    logic [1:0]         sel_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_deg_reg;

    logic [2:0]  s_func;
    logic        s_fire;
    logic        out_free;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [2:0]         acc_idx;

    iu_ctrl_t    iu_ctrl;
    logic [95:0] iu_src;
    logic [65:0] iu_rem;
    logic [63:0] iu_dsr;
    logic [65:0] iu_quo;
    logic        iu_sticky;
    logic        iu_done;
    logic [5:0]  wsh;

    logic signed [32:0] dt [0:2];
    logic signed [32:0] dg [0:2];
    logic signed [32:0] nrm_ext [0:2];
    logic               any_hi, all_lo, face_zero;
    logic [49:0]        q_raw;
    logic [47:0]        q_sat;
    logic signed [31:0] dist_sel;

    assign s_func   = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign acc_idx  = cnt_reg - 3'd1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dt[i]      = {cen_reg[i][31], cen_reg[i]} - {node_reg[i][31], node_reg[i]};
            dg[i]      = {cen_reg[i][31], cen_reg[i]} - {pn_reg[i][31], pn_reg[i]};
            nrm_ext[i] = {{17{nrm_reg[i][15]}}, nrm_reg[i]};
        end
        any_hi = 1'b0;
        all_lo = 1'b1;
        face_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            any_hi    = any_hi | (|u_reg[i][63:31]);
            all_lo    = all_lo & ~(|u_reg[i][63:30]);
            face_zero = face_zero & (c_reg[i] == 64'sd0);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_func == SLOT_NBR) state_next = ST_EDGE;
            end
            ST_EDGE:   state_next = ST_CROSS;
            ST_CROSS: begin
                if (cnt_reg == 3'd6) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (face_zero || vi_reg == '0 || vj_reg == '0) state_next = ST_DONE;
                else state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (!any_hi && !all_lo) state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                if (cnt_reg == 3'd3) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (iu_done) state_next = ST_NDIV;
            end
            ST_NDIV: begin
                if (iu_done && sel_reg == 2'd2) state_next = ST_DOT_T;
            end
            ST_DOT_T: begin
                if (cnt_reg == 3'd3) state_next = ST_FLIP;
            end
            ST_FLIP:   state_next = ST_DOT_G;
            ST_DOT_G: begin
                if (cnt_reg == 3'd3) state_next = ST_VOL;
            end
            ST_VOL: begin
                if (cnt_reg == 3'd1) state_next = ST_WDIV;
            end
            ST_WDIV: begin
                if (iu_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs: multiplier operands and iterative unit commands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CROSS: begin
                case (cnt_reg)
                    3'd0: begin mul_a = 33'(a_reg[1]); mul_b = 33'(b_reg[2]); end
                    3'd1: begin mul_a = 33'(a_reg[2]); mul_b = 33'(b_reg[1]); end
                    3'd2: begin mul_a = 33'(a_reg[2]); mul_b = 33'(b_reg[0]); end
                    3'd3: begin mul_a = 33'(a_reg[0]); mul_b = 33'(b_reg[2]); end
                    3'd4: begin mul_a = 33'(a_reg[0]); mul_b = 33'(b_reg[1]); end
                    3'd5: begin mul_a = 33'(a_reg[1]); mul_b = 33'(b_reg[0]); end
                    default: ;
                endcase
            end
            ST_SQUARE, ST_DOT_T, ST_DOT_G: begin
                if (cnt_reg < 3'd3) begin
                    if (state_reg == ST_SQUARE) begin
                        mul_a = {2'b00, u_reg[cnt_reg[1:0]][30:0]};
                        mul_b = {2'b00, u_reg[cnt_reg[1:0]][30:0]};
                    end else if (state_reg == ST_DOT_T) begin
                        mul_a = dt[cnt_reg[1:0]];
                        mul_b = nrm_ext[cnt_reg[1:0]];
                    end else begin
                        mul_a = dg[cnt_reg[1:0]];
                        mul_b = nrm_ext[cnt_reg[1:0]];
                    end
                end
            end
            ST_VOL: begin
                mul_a = {1'b0, vi_reg};
                mul_b = {1'b0, vj_reg};
            end
            default: ;
        endcase

        wsh = 6'(s_reg + 7'(WDIV_PRE + FRAC_BITS - 2));
        iu_ctrl.start = 1'b0;
        iu_ctrl.mode  = IU_SQRT;
        iu_src = '0;
        iu_rem = '0;
        iu_dsr = '0;
        case (state_reg)
            ST_SQRT: begin
                iu_ctrl.start = (cnt_reg == 3'd0);
                iu_src = {sum_reg, 32'd0};
            end
            ST_NDIV: begin
                iu_ctrl.start = (cnt_reg == 3'd0);
                iu_ctrl.mode  = IU_NDIV;
                iu_rem = {35'd0, u_reg[sel_reg][30:0]};
                iu_dsr = {32'd0, m_reg};
            end
            ST_WDIV: begin
                iu_ctrl.start = (cnt_reg == 3'd0);
                iu_ctrl.mode  = IU_WDIV;
                iu_src = {64'd0, m_reg} << wsh;
                iu_dsr = p_reg;
            end
            default: ;
        endcase
    end

    // weight saturation and distance selection
    always_comb begin
        q_raw = iu_quo[65:WDIV_PRE];
        if (iu_sticky || q_raw > 50'h0_8000_0000_0000) begin
            q_sat = 48'h8000_0000_0000;
        end else begin
            q_sat = q_raw[47:0];
        end
        if (code_reg == CODE_INTERIOR) begin
            dist_sel = sat32(53'(g_reg >>> NORM_FRAC));
        end else if (is_wall(code_reg)) begin
            dist_sel = sat32(53'({t_reg, 1'b0}) >>> NORM_FRAC);
        end else begin
            dist_sel = '0;
        end
    end

    fvm_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    fvm_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (iu_ctrl),
        .src_in  (iu_src),
        .rem_in  (iu_rem),
        .dsr_in  (iu_dsr),
        .quo     (iu_quo),
        .sticky  (iu_sticky),
        .done    (iu_done)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) begin
                cnt_reg <= '0;
                sel_reg <= '0;
            end else if (state_reg == ST_NDIV && iu_done) begin
                // next normal component
                cnt_reg <= '0;
                sel_reg <= sel_reg + 2'd1;
            end else if (cnt_reg != 3'd7) begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            case (s_func)
                3'd0, 3'd1, 3'd2: begin
                    node_reg[4'(s_func) * 4'd3]        <= s_tdata[31:0];
                    node_reg[4'(s_func) * 4'd3 + 4'd1] <= s_tdata[63:32];
                    node_reg[4'(s_func) * 4'd3 + 4'd2] <= s_tdata[95:64];
                end
                SLOT_CELL: begin
                    cen_reg[0] <= s_tdata[31:0];
                    cen_reg[1] <= s_tdata[63:32];
                    cen_reg[2] <= s_tdata[95:64];
                    vi_reg     <= s_tdata[127:96];
                end
                SLOT_NBR: begin
                    pn_reg[0] <= s_tdata[31:0];
                    pn_reg[1] <= s_tdata[63:32];
                    pn_reg[2] <= s_tdata[95:64];
                    vj_reg    <= s_tdata[127:96];
                    code_reg  <= s_tdata[133:128];
                    nbr_reg   <= s_tdata[153:134];
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i] <= sat31(33'(node_reg[i]) - 33'(node_reg[3 + i]));
                    b_reg[i] <= sat31(33'(node_reg[i]) - 33'(node_reg[6 + i]));
                end
            end
            ST_CROSS: begin
                if (cnt_reg != 3'd0) begin
                    if (!acc_idx[0]) c_reg[acc_idx[2:1]] <= prod[63:0];
                    else c_reg[acc_idx[2:1]] <= c_reg[acc_idx[2:1]] - prod[63:0];
                end
            end
            ST_CHECK: begin
                deg_reg <= face_zero || vi_reg == '0 || vj_reg == '0;
                s_reg   <= '0;
                for (int i = 0; i < 3; i++) begin
                    u_reg[i] <= c_reg[i][63] ? 64'(-c_reg[i]) : 64'(c_reg[i]);
                end
            end
            ST_SHIFT: begin
                if (any_hi) begin
                    s_reg <= s_reg + 7'sd1;
                    for (int i = 0; i < 3; i++) u_reg[i] <= u_reg[i] >> 1;
                end else if (all_lo) begin
                    s_reg <= s_reg - 7'sd1;
                    for (int i = 0; i < 3; i++) u_reg[i] <= u_reg[i] << 1;
                end
            end
            ST_SQUARE: begin
                if (cnt_reg == 3'd1) sum_reg <= prod[63:0];
                else if (cnt_reg != 3'd0) sum_reg <= sum_reg + prod[63:0];
            end
            ST_SQRT: begin
                if (iu_done) m_reg <= iu_quo[31:0];
            end
            ST_NDIV: begin
                if (iu_done) begin
                    nrm_reg[sel_reg] <= c_reg[sel_reg][63] ? -16'(iu_quo[14:0])
                                                           : 16'(iu_quo[14:0]);
                end
            end
            ST_DOT_T: begin
                if (cnt_reg == 3'd1) t_reg <= prod[51:0];
                else if (cnt_reg != 3'd0) t_reg <= t_reg + prod[51:0];
            end
            ST_FLIP: begin
                // turn the normal toward the cell centre
                if (t_reg[51]) begin
                    t_reg <= -t_reg;
                    for (int i = 0; i < 3; i++) nrm_reg[i] <= -nrm_reg[i];
                end
            end
            ST_DOT_G: begin
                if (cnt_reg == 3'd1) g_reg <= prod[51:0];
                else if (cnt_reg != 3'd0) g_reg <= g_reg + prod[51:0];
            end
            ST_VOL: begin
                if (cnt_reg == 3'd1) p_reg <= prod[63:0];
            end
            ST_WDIV: begin
                if (iu_done) wgt_reg <= 48'd0 - q_sat;
            end
            default: ;
        endcase

        if (state_reg == ST_DONE && out_free) begin
            out_deg_reg <= deg_reg;
            if (deg_reg) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {4'd0, nbr_reg, wgt_reg, dist_sel,
                                 nrm_reg[2], nrm_reg[1], nrm_reg[0]};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

endmodule

`default_nettype wire

// ===== bench/fvm_face_normal_distance_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fvm_face_normal_distance_chk: result checker for the face geometry block
// Watches both stream channels. It keeps the nodes and cell centre of accepted
// beats, models the face geometry bit-exactly for each slot 4 beat, queues the
// expected result and compares it field by field with every accepted output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fvm_face_normal_distance_chk (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [fvm_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [2:0]                   s_tuser,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [fvm_pkg::M_DATA_W-1:0] m_tdata,
    input  wire logic [0:0]                   m_tuser,
    output int                                fail_count,
    output int                                pending
);
    import fvm_pkg::*;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] ndist;
        logic signed [47:0] wgt;
        logic [19:0]        nbr;
        logic               degen;
    } face_res_t;

    localparam logic [63:0] WGT_LIMIT = 64'd1 << 47;

    longint    node_xyz [9];
    longint    cell_xyz [3];
    longint    vol_i;
    face_res_t face_q [$];

    function automatic longint clamp31(input longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh7FFF_FFFF) return -64'sh7FFF_FFFF;
        return v;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] weight_quot(input logic [63:0] m, input int e,
                                                input logic [63:0] p);
        logic [63:0] q, r;
        logic        carry;
        if (e < 0) begin
            q = (m >> (-e)) / p;
            return (q > WGT_LIMIT) ? WGT_LIMIT : q;
        end
        q = m / p;
        r = m % p;
        if (q > WGT_LIMIT) return WGT_LIMIT;
        for (int i = 0; i < e; i++) begin
            carry = r[63];
            r = r << 1;
            q = q << 1;
            if (carry || r >= p) begin
                r -= p;
                q[0] = 1'b1;
            end
            if (q > WGT_LIMIT) return WGT_LIMIT;
        end
        return q;
    endfunction

    function automatic face_res_t face_geometry(input logic [S_DATA_W-1:0] d);
        face_res_t          res;
        longint             pt [3], ea [3], eb [3], cr [3], nv [3];
        longint unsigned    mag [3], mx, sq;
        logic [63:0]        root, vj, q;
        logic [5:0]         code;
        longint             t, g;
        int                 s;
        res = '0;
        for (int i = 0; i < 3; i++) pt[i] = longint'($signed(d[32*i +: 32]));
        vj   = {32'd0, d[127:96]};
        code = d[133:128];
        for (int i = 0; i < 3; i++) begin
            ea[i] = clamp31(node_xyz[i] - node_xyz[3+i]);
            eb[i] = clamp31(node_xyz[i] - node_xyz[6+i]);
        end
        cr[0] = ea[1]*eb[2] - ea[2]*eb[1];
        cr[1] = ea[2]*eb[0] - ea[0]*eb[2];
        cr[2] = ea[0]*eb[1] - ea[1]*eb[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? -cr[i] : cr[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0 || vol_i == 0 || vj == 0) begin
            res.degen = 1'b1;
            return res;
        end
        s = 0;
        while (mx >= (64'd1 << 31)) begin mx >>= 1; s++; end
        while (mx < (64'd1 << 30)) begin mx <<= 1; s--; end
        for (int i = 0; i < 3; i++) mag[i] = (s >= 0) ? (mag[i] >> s) : (mag[i] << (-s));
        sq   = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
        root = int_sqrt(sq);
        t = 0;
        for (int i = 0; i < 3; i++) begin
            nv[i] = longint'((mag[i] << NORM_FRAC) / root);
            if (cr[i] < 0) nv[i] = -nv[i];
            t += (cell_xyz[i] - node_xyz[i]) * nv[i];
        end
        // turn the normal toward the cell centre
        if (t < 0) begin
            for (int i = 0; i < 3; i++) nv[i] = -nv[i];
            t = -t;
        end
        if (code == CODE_INTERIOR) begin
            g = 0;
            for (int i = 0; i < 3; i++) g += (cell_xyz[i] - pt[i]) * nv[i];
            res.ndist = clamp32(g >>> NORM_FRAC);
        end else if (code inside {6'd3, 6'd4, 6'd5, 6'd7, 6'd9, 6'd10, 6'd36}) begin
            res.ndist = clamp32((2*t) >>> NORM_FRAC);
        end
        q = weight_quot(root, s + FRAC_BITS - 2, vol_i * vj);
        res.nx  = nv[0][15:0];
        res.ny  = nv[1][15:0];
        res.nz  = nv[2][15:0];
        res.wgt = -q[47:0];
        res.nbr = d[153:134];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        face_res_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) node_xyz[i] = 0;
            for (int i = 0; i < 3; i++) cell_xyz[i] = 0;
            vol_i = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.nx    = m_tdata[15:0];
                got.ny    = m_tdata[31:16];
                got.nz    = m_tdata[47:32];
                got.ndist = m_tdata[79:48];
                got.wgt   = m_tdata[127:80];
                got.nbr   = m_tdata[147:128];
                got.degen = m_tuser[0];
                if (face_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    want = face_q.pop_front();
                    if (got.nx != want.nx) report_mismatch("normal_x", got.nx, want.nx);
                    if (got.ny != want.ny) report_mismatch("normal_y", got.ny, want.ny);
                    if (got.nz != want.nz) report_mismatch("normal_z", got.nz, want.nz);
                    if (got.ndist != want.ndist)
                        report_mismatch("distance", got.ndist, want.ndist);
                    if (got.wgt != want.wgt)
                        report_mismatch("weight_gradient", got.wgt, want.wgt);
                    if (got.nbr != want.nbr)
                        report_mismatch("neighbor_out", got.nbr, want.nbr);
                    if (got.degen != want.degen)
                        report_mismatch("degenerate", got.degen, want.degen);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser < 3) begin
                    for (int i = 0; i < 3; i++)
                        node_xyz[s_tuser*3 + i] = longint'($signed(s_tdata[32*i +: 32]));
                end else if (s_tuser == SLOT_CELL) begin
                    for (int i = 0; i < 3; i++)
                        cell_xyz[i] = longint'($signed(s_tdata[32*i +: 32]));
                    vol_i = longint'({32'd0, s_tdata[127:96]});
                end else if (s_tuser == SLOT_NBR) begin
                    face_q.insert(face_q.size(), face_geometry(s_tdata));
                end
            end
        end
        pending = face_q.size();
    end

endmodule

`default_nettype wire

// ===== bench/fvm_face_normal_distance_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fvm_face_normal_distance_tb: regression bench for the face geometry block
// Loads faces beat by beat: directed extremes and special cases first, a sink
// hold-off next, then random faces, mostly complete five-beat faces with some
// stray and ignored slots, mostly under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module fvm_face_normal_distance_tb;
    import fvm_pkg::*;

    localparam int NUM_RANDOM_FACES = 160;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [0:0]           m_tuser;
    int                   fail_count;
    int                   pending;
    bit                   gaps_on;
    bit                   hold_sink;

    fvm_face_normal_distance u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fvm_face_normal_distance_chk u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // sink side: random stalls, plus a hold-off when asked
    initial m_tready = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= gaps_on ? ($urandom_range(99) >= 31) : 1'b1;
        end
    end

    initial begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // leave tvalid up after the beat; the caller drops it after the last one
    task automatic send_point(input logic [2:0] slot, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input logic [31:0] vol, input logic [5:0] code,
                              input logic [19:0] nbr);
        if (gaps_on) begin
            while ($urandom_range(99) < 31) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= slot;
        s_tdata  <= {6'd0, nbr, code, vol, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(input int span);
        case ($urandom_range(9))
            0: return $urandom();
            1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return $signed(32'($urandom_range(2*span))) - span;
        endcase
    endfunction

    function automatic logic [31:0] rand_volume();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(32'h0004_0000, 32'h0000_0100);
        endcase
    endfunction

    function automatic logic [5:0] rand_code();
        case ($urandom_range(5))
            0, 1: return CODE_INTERIOR;
            2, 3: begin
                case ($urandom_range(6))
                    0: return 6'd3;
                    1: return 6'd4;
                    2: return 6'd5;
                    3: return 6'd7;
                    4: return 6'd9;
                    5: return 6'd10;
                    default: return 6'd36;
                endcase
            end
            default: return 6'($urandom());
        endcase
    endfunction

    task automatic send_face(input int span);
        for (int i = 0; i < 3; i++)
            send_point(3'(i), rand_coord(span), rand_coord(span), rand_coord(span),
                       $urandom(), 6'($urandom()), 20'($urandom()));
        send_point(SLOT_CELL, rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_volume(), 6'($urandom()), 20'($urandom()));
        send_point(SLOT_NBR, rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_volume(), rand_code(), 20'($urandom()));
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int span;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        gaps_on  = 1'b0;
        hold_sink = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // unit right triangle in the z=0 plane, centres above and below
        send_point(3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0, 20'd0);
        send_point(3'd1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 6'd0, 20'd0);
        send_point(3'd2, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 6'd0, 20'd0);
        send_point(SLOT_CELL, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 6'd0, 20'd0);
        send_point(SLOT_NBR, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000,
                   CODE_INTERIOR, 20'hFFFFF);
        send_point(SLOT_NBR, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 6'd36, 20'h12345);
        send_point(SLOT_NBR, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 6'd63, 20'd0);
        // zero neighbour volume, then two ignored slots
        send_point(SLOT_NBR, 32'h0, 32'h0, 32'h0, 32'h0, 6'd3, 20'd7);
        send_point(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   6'h3F, 20'hFFFFF);
        send_point(3'd5, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 6'd0, 20'd0);
        // extreme nodes: edges saturate, unit volumes saturate the weight
        send_point(3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 6'd0, 20'd0);
        send_point(3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 6'd0, 20'd0);
        send_point(3'd2, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 6'd0, 20'd0);
        send_point(SLOT_CELL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h0000_0001, 6'd0, 20'd0);
        send_point(SLOT_NBR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                   CODE_INTERIOR, 20'h0);
        send_point(SLOT_NBR, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 6'd10, 20'h1);
        // collapsed face: all nodes equal
        send_point(3'd0, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0, 6'd0, 20'd0);
        send_point(3'd1, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0, 6'd0, 20'd0);
        send_point(3'd2, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 32'h0, 6'd0, 20'd0);
        send_point(SLOT_NBR, 32'h1, 32'h1, 32'h1, 32'h0001_0000, 6'd4, 20'h55555);
        // zero cell volume
        send_point(3'd2, 32'h0, 32'h0005_0000, 32'h0001_0000, 32'h0, 6'd0, 20'd0);
        send_point(SLOT_CELL, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0, 20'd0);
        send_point(SLOT_NBR, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 6'd5, 20'hAAAAA);
        s_tvalid <= 1'b0;
        drain();

        // sender keeps offering while the sink holds off
        fork
            begin
                hold_sink = 1'b1;
                repeat (3000) @(negedge aclk);
                hold_sink = 1'b0;
            end
            begin
                repeat (3) send_face(32'h0010_0000);
                s_tvalid <= 1'b0;
            end
        join
        drain();

        gaps_on = 1'b1;
        for (int f = 0; f < NUM_RANDOM_FACES; f++) begin
            span = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF : 32'h0040_0000;
            if (f % 10 == 9) begin
                // a stray slot and a bare recompute on the current state
                send_point(3'($urandom_range(7, 5)), $urandom(), $urandom(), $urandom(),
                           $urandom(), 6'($urandom()), 20'($urandom()));
                send_point(SLOT_NBR, rand_coord(span), rand_coord(span), rand_coord(span),
                           rand_volume(), rand_code(), 20'($urandom()));
            end
            send_face(span);
            if (f == NUM_RANDOM_FACES / 2) gaps_on = 1'b0;
            if (f == NUM_RANDOM_FACES / 2 + 20) gaps_on = 1'b1;
        end
        s_tvalid <= 1'b0;

        drain();
        repeat (300) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/fvm_pkg.sv
hw/rtl/fvm_mul.sv
hw/rtl/fvm_iter_unit.sv
hw/rtl/fvm_face_normal_distance.sv
bench/fvm_face_normal_distance_chk.sv
bench/fvm_face_normal_distance_tb.sv
